// ----- hw/rtl/ssd_pkg.sv -----
// Shared types, constants and helper functions for the seven-segment scan driver.
// No dependencies; every other file in this block imports it.
package ssd_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int DIGIT_W    = 4;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int VALUE_W    = 14;
  localparam int SEG_W      = 7;
  localparam int TICK_W     = 8;
  localparam int COUNT_W    = 3;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [VALUE_W-1:0] MAX_VALUE   = VALUE_W'(9999);
  localparam logic [VALUE_W-1:0] W_THOUSANDS = VALUE_W'(1000);
  localparam logic [VALUE_W-1:0] W_HUNDREDS  = VALUE_W'(100);
  localparam logic [VALUE_W-1:0] W_TENS      = VALUE_W'(10);

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_BLANK   = 2'd0;
  localparam logic [1:0] REG_COUNT   = 2'd1;
  localparam logic [1:0] REG_REFRESH = 2'd2;

  localparam logic                RST_BLANK   = 1'b0;
  localparam logic [COUNT_W-1:0]  RST_COUNT   = COUNT_W'(4);
  localparam logic [TICK_W-1:0]   RST_REFRESH = TICK_W'(3);

  typedef struct packed {
    logic               blank_leading;
    logic [COUNT_W-1:0] digit_count;
    logic [TICK_W-1:0]  refresh_ticks;
  } cfg_t;

  // One word leaving the conversion pipeline toward the scan stage.
  typedef struct packed {
    logic                                valid;
    logic                                load;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits;
  } item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] rem;
  } divmod_t;

  // One decimal digit of x by a bank of parallel compares against the
  // multiples of the weight, then the remainder. Needs x < 10 * weight.
  function automatic divmod_t divmod_step(input logic [VALUE_W-1:0] x,
                                          input logic [VALUE_W-1:0] weight);
    divmod_t r;
    r.digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (x >= VALUE_W'(k) * weight) begin
        r.digit = DIGIT_W'(k);
      end
    end
    r.rem = x - VALUE_W'(r.digit) * weight;
    return r;
  endfunction

  // Segment pattern, bit 0 = a through bit 6 = g; codes above nine are dark.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7C;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/ssd_cfg.sv -----
// APB-style register file for the scan driver: blanking, digit count, refresh period.
// Depends on ssd_pkg.
module ssd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssd_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssd_pkg::DATA_W-1:0]  pwdata,
  output logic [ssd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ssd_pkg::cfg_t               cfg
);
  import ssd_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blank_leading <= RST_BLANK;
      cfg.digit_count   <= RST_COUNT;
      cfg.refresh_ticks <= RST_REFRESH;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_BLANK:   cfg.blank_leading <= pwdata[0];
        REG_COUNT:   cfg.digit_count   <= pwdata[COUNT_W-1:0];
        REG_REFRESH: cfg.refresh_ticks <= pwdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BLANK:   prdata = DATA_W'(cfg.blank_leading);
      REG_COUNT:   prdata = DATA_W'(cfg.digit_count);
      REG_REFRESH: prdata = DATA_W'(cfg.refresh_ticks);
      default:     prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/ssd_bcd_conv.sv -----
// Three-stage pipeline that splits a display value into four decimal digits: thousands
// into s1, hundreds into s2, tens and units from s2. Tick words ride along unchanged. Depends on ssd_pkg.
module ssd_bcd_conv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         in_valid,
  input  logic                         func,
  input  logic [ssd_pkg::VALUE_W-1:0]  value,
  output ssd_pkg::item_t               item
);
  import ssd_pkg::*;

  logic                 s0_valid;
  logic                 s0_load;
  logic [VALUE_W-1:0]   s0_value;

  logic                 s1_valid;
  logic                 s1_load;
  logic [DIGIT_W-1:0]   s1_thou;
  logic [9:0]           s1_rem;

  logic                 s2_valid;
  logic                 s2_load;
  logic [DIGIT_W-1:0]   s2_thou;
  logic [DIGIT_W-1:0]   s2_hund;
  logic [6:0]           s2_rem;

  divmod_t              dm_thou;
  divmod_t              dm_hund;
  divmod_t              dm_tens;

  assign dm_thou = divmod_step(s0_value, W_THOUSANDS);
  assign dm_hund = divmod_step(VALUE_W'(s1_rem), W_HUNDREDS);
  assign dm_tens = divmod_step(VALUE_W'(s2_rem), W_TENS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= in_valid;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_load  <= func;
      s0_value <= (value > MAX_VALUE) ? MAX_VALUE : value;
      s1_load  <= s0_load;
      s1_thou  <= dm_thou.digit;
      s1_rem   <= dm_thou.rem[9:0];
      s2_load  <= s1_load;
      s2_thou  <= s1_thou;
      s2_hund  <= dm_hund.digit;
      s2_rem   <= dm_hund.rem[6:0];
    end
  end

  assign item.valid     = s2_valid;
  assign item.load      = s2_load;
  assign item.digits[3] = s2_thou;
  assign item.digits[2] = s2_hund;
  assign item.digits[1] = dm_tens.digit;
  assign item.digits[0] = dm_tens.rem[DIGIT_W-1:0];

  a_thou_digit: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_load |-> s1_thou <= DIGIT_W'(9) && s1_rem < 10'd1000)
    else $error("thousands step left an out-of-range digit or remainder");

  a_hund_digit: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_load |-> s2_hund <= DIGIT_W'(9) && s2_rem < 7'd100)
    else $error("hundreds step left an out-of-range digit or remainder");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(s2_valid) && $stable(s2_load) && $stable(s2_rem))
    else $error("pipeline moved while stalled");

endmodule

// ----- hw/rtl/ssd_scan.sv -----
// Scan stage: digit store, tick counter, scan index and the result register.
// Depends on ssd_pkg.
module ssd_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  ssd_pkg::item_t              item,
  input  ssd_pkg::cfg_t               cfg,
  output logic                        out_valid,
  output logic [ssd_pkg::NUM_DIGITS-1:0] digit_enable,
  output logic [ssd_pkg::SEG_W-1:0]   segments,
  output logic [ssd_pkg::IDX_W-1:0]   digit_index
);
  import ssd_pkg::*;

  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_store;
  logic [TICK_W-1:0]                  tick_count;
  logic [IDX_W-1:0]                   scan_index;

  logic [TICK_W-1:0]                  tick_inc;
  logic                               fire;
  logic                               is_tick;
  logic [NUM_DIGITS-1:0]              upper_nz;
  logic                               lit;
  logic [IDX_W:0]                     idx_inc;
  logic [IDX_W-1:0]                   scan_index_next;
  logic [NUM_DIGITS-1:0]              enable_next;

  assign is_tick  = item.valid && !item.load;
  assign tick_inc = tick_count + TICK_W'(1);
  assign fire     = !(tick_inc < cfg.refresh_ticks);

  // upper_nz[k] is set when any digit at position k or above is nonzero.
  always_comb begin
    upper_nz[NUM_DIGITS-1] = |digit_store[NUM_DIGITS-1];
    for (int k = NUM_DIGITS - 2; k >= 0; k--) begin
      upper_nz[k] = (|digit_store[k]) || upper_nz[k+1];
    end
  end

  assign lit = !cfg.blank_leading || (scan_index == '0) || upper_nz[scan_index];
  assign enable_next = lit ? (NUM_DIGITS'(1) << scan_index) : '0;

  assign idx_inc = {1'b0, scan_index} + (IDX_W+1)'(1);
  assign scan_index_next = ((COUNT_W'(idx_inc) >= cfg.digit_count) ||
                            (idx_inc >= (IDX_W+1)'(NUM_DIGITS))) ? '0 : idx_inc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_store <= '0;
      tick_count  <= '0;
      scan_index  <= '0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      out_valid <= is_tick && fire;
      if (item.valid && item.load) begin
        digit_store <= item.digits;
      end
      if (is_tick) begin
        tick_count <= fire ? '0 : tick_inc;
        if (fire) begin
          scan_index <= scan_index_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_tick && fire) begin
      digit_enable <= enable_next;
      segments     <= seg_pattern(digit_store[scan_index]);
      digit_index  <= scan_index;
    end
  end

  a_enable_matches_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_enable != '0 |-> digit_enable == (NUM_DIGITS'(1) << digit_index))
    else $error("digit enable does not match the scanned index");

  a_first_digit_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_index == '0 |-> digit_enable == NUM_DIGITS'(1))
    else $error("least significant digit was blanked");

  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    advance && is_tick && fire |=> tick_count == '0)
    else $error("tick counter did not clear after a scan step");

endmodule

// ----- hw/rtl/seven_segment_scan_driver_unit.sv -----
// Multiplexed four-digit seven-segment scan driver. Each input word is either a
// tick (func = 0) or a display value to load (func = 1, saturated to 9999). The block
// takes one word per clock cycle while in_ready is high. A word passes through the s0,
// s1 and s2 registers of the three-stage decimal conversion pipeline to the scan stage,
// and a tick's scan step is registered in the output register as the scan stage takes it.
// Words stay in order, so a tick always sees every earlier load. A stalled output holds
// the whole pipeline, and in_ready is high whenever the output register is empty or being
// taken. Registers: blank_leading at 0x0, digit_count at 0x4, refresh_ticks at 0x8;
// the user must write them only while the block is idle; the block itself does not enforce it.
module seven_segment_scan_driver_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic [ssd_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ssd_pkg::NUM_DIGITS-1:0] digit_enable,
  output logic [ssd_pkg::SEG_W-1:0]    segments,
  output logic [ssd_pkg::IDX_W-1:0]    digit_index,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ssd_pkg::DATA_W-1:0]   pwdata,
  output logic [ssd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import ssd_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  advance;

  // The pipeline moves whenever the result register is free or is being drained.
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  ssd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssd_bcd_conv u_conv (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (in_valid),
    .func     (func),
    .value    (value),
    .item     (item)
  );

  ssd_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (item),
    .cfg          (cfg),
    .out_valid    (out_valid),
    .digit_enable (digit_enable),
    .segments     (segments),
    .digit_index  (digit_index)
  );

endmodule
